// ===== hdl/pdr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package for the pulse duration recorder: widths, register map, item kinds
// and the output stage record. No dependencies.
package pdr_pkg;

    localparam int unsigned DEF_MAX_RECORDS = 256;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned CAP_W      = 9;
    localparam int unsigned CNT_OUT_W  = 9;
    localparam int unsigned IDX_OUT_W  = 8;

    // stream tdata payloads padded to whole bytes
    localparam int unsigned S_TDATA_W  = 40;
    localparam int unsigned S_TUSER_W  = 1;
    localparam int unsigned M_TDATA_W  = 184;

    // APB register port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_IDLE_LEVEL      = 1'b0,
        REG_RECORD_CAPACITY = 1'b1
    } t_reg_idx;

    typedef enum logic {
        KIND_EVENT = 1'b0,
        KIND_CLEAR = 1'b1
    } t_kind;

    // result held in the output stage; the pause of a closed record and the
    // newest signal duration of an untouched record come from the store
    typedef struct packed {
        logic                 store_full;
        logic [TIME_W-1:0]    first_time;
        logic [TIME_W-1:0]    last_time;
        logic [TIME_W-1:0]    span;
        logic                 wrote;
        logic [IDX_OUT_W-1:0] written_index;
        logic [TIME_W-1:0]    written_pause;
        logic [TIME_W-1:0]    written_signal;
        logic                 pause_from_ram;
        logic                 sig_known;
        logic                 sig_nz;
    } t_out_stage;

endpackage
`default_nettype wire

// ===== hdl/pdr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pdr_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read-first: a read and a write of one address in one cycle return old data
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/pulse_duration_recorder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pulse duration recorder, top level: state registers, record store and
// output stage. Depends on pdr_pkg and pdr_ram.
//
// Channel    Dir   Handshake                    Payload
// s_axis     in    s_axis_tvalid/s_axis_tready   tdata: event_time, level; tuser: kind
// m_axis     out   m_axis_tvalid/m_axis_tready   tdata: status and written record
// apb        in    psel/penable/pwrite, pready=1 idle_level @0x0, record_capacity @0x4
//
// One transfer in per cycle while the output stage can take it, one result out per
// cycle while the sink takes it; each result appears in the cycle after its input
// transfer. Recorder state updates at the input transfer or a capacity write; the
// store is read at the newest record in that cycle to complete the output stage.
// Reset: synchronous, active low; no clearing pass, read data from an entry
// that was not written is never used.
// Output stall: the output stage takes a new transfer whenever it is empty or
// its result is taken in the same cycle.
module pulse_duration_recorder_top
    import pdr_pkg::*;
#(
    parameter int MAX_RECORDS = pdr_pkg::DEF_MAX_RECORDS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // slave stream
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [31:0] event_time, [39:32] level
    input  wire logic [pdr_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [0] kind
    input  wire logic [pdr_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    // master stream
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [8:0] complete_count, [9] store_full, [41:10] first_time,
    // [73:42] last_time, [105:74] span, [106] wrote, [114:107] written_index,
    // [146:115] written_pause, [178:147] written_signal, [183:179] zero
    output logic      [pdr_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // APB configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pdr_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [pdr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [pdr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready
);

    // fill count holds 0..MAX_RECORDS; store address holds 0..MAX_RECORDS-1
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    // common width for capacity compares and count/index results
    localparam int XW = (CW > CAP_W) ? CW : CAP_W;
    localparam int IW = (CW > IDX_OUT_W) ? CW : IDX_OUT_W;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [LEVEL_W-1:0] r_idle_level;
    logic [CAP_W-1:0]   r_record_capacity;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[2]);

    always_comb begin
        unique case (cfg_idx)
            REG_IDLE_LEVEL:      prdata = APB_DATA_W'(r_idle_level);
            REG_RECORD_CAPACITY: prdata = APB_DATA_W'(r_record_capacity);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_level      <= '0;
            r_record_capacity <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_IDLE_LEVEL:      r_idle_level      <= pwdata[LEVEL_W-1:0];
                REG_RECORD_CAPACITY: r_record_capacity <= pwdata[CAP_W-1:0];
                default:             r_idle_level      <= r_idle_level;
            endcase
        end
    end

    // capacity above the store depth saturates
    logic [XW-1:0] cap_x;
    logic [CW-1:0] eff_cap;

    assign cap_x   = XW'(r_record_capacity);
    assign eff_cap = (cap_x > XW'(MAX_RECORDS)) ? CW'(MAX_RECORDS) : CW'(cap_x);

    // ---------------------------------------------------------------
    // Recorder state
    // ---------------------------------------------------------------
    logic [CW-1:0]      r_fill,       n_fill;
    logic [TIME_W-1:0]  r_start_time, n_start_time;
    logic [TIME_W-1:0]  r_prev_time,  n_prev_time;
    logic [LEVEL_W-1:0] r_prev_level, n_prev_level;

    logic               r_out_valid;
    logic [CW-1:0]      r_out_fill;
    t_out_stage         r_out, n_out;

    logic               in_xfer;
    t_kind              in_kind;
    logic [TIME_W-1:0]  in_time;
    logic [LEVEL_W-1:0] in_level;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign in_kind       = t_kind'(s_axis_tuser[0]);
    assign in_time       = s_axis_tdata[TIME_W-1:0];
    assign in_level      = s_axis_tdata[TIME_W +: LEVEL_W];

    // event decode
    logic              fill_empty, has_room, is_active, leaves_idle;
    logic              do_append, do_close, take_time, is_event;
    logic [TIME_W-1:0] passed;
    logic [CW-1:0]     fill_m1;
    logic [IW-1:0]     widx_x;

    assign is_event    = in_kind == KIND_EVENT;
    assign fill_empty  = r_fill == '0;
    assign has_room    = r_fill < eff_cap;
    assign leaves_idle = in_level != r_idle_level;
    // repeated level is dropped once the store holds a record
    assign is_active   = is_event && (eff_cap != '0)
                         && !((in_level == r_prev_level) && !fill_empty);
    assign passed      = in_time - r_prev_time;
    assign fill_m1     = r_fill - CW'(1);
    assign do_append   = is_active && leaves_idle && has_room;
    assign do_close    = is_active && !leaves_idle && !fill_empty;
    // append into a full store leaves the time and level untouched
    assign take_time   = is_active && (!leaves_idle || has_room);
    assign widx_x      = do_append ? IW'(r_fill) : IW'(fill_m1);

    always_comb begin
        n_fill       = r_fill;
        n_start_time = r_start_time;
        n_prev_time  = r_prev_time;
        n_prev_level = r_prev_level;

        if (in_xfer) begin
            unique case (in_kind)
                KIND_CLEAR: begin
                    n_fill       = '0;
                    n_start_time = '0;
                    n_prev_time  = '0;
                    n_prev_level = r_idle_level;
                end
                KIND_EVENT: begin
                    if (is_active && leaves_idle && fill_empty) begin
                        n_start_time = in_time;
                    end
                    if (do_append) begin
                        n_fill = r_fill + CW'(1);
                    end
                    if (take_time) begin
                        n_prev_time  = in_time;
                        n_prev_level = in_level;
                    end
                end
                default: n_fill = r_fill;
            endcase
        end
        // capacity write empties the store; the user must write it only while idle, the block does not enforce this
        if (cfg_wr && (cfg_idx == REG_RECORD_CAPACITY)) begin
            n_fill = '0;
        end
    end

    always_comb begin
        n_out                = '0;
        n_out.store_full     = (n_fill == eff_cap) && (n_prev_level == r_idle_level);
        n_out.first_time     = n_start_time;
        n_out.last_time      = n_prev_time;
        n_out.span           = n_prev_time - n_start_time;
        n_out.wrote          = do_append || do_close;
        n_out.pause_from_ram = do_close;
        n_out.sig_known      = !is_event || do_append || do_close;
        n_out.sig_nz         = do_close && (passed != '0);
        if (do_append || do_close) begin
            n_out.written_index = widx_x[IDX_OUT_W-1:0];
        end
        if (do_append) begin
            n_out.written_pause = fill_empty ? '0 : passed;
        end
        if (do_close) begin
            n_out.written_signal = passed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_start_time <= '0;
            r_prev_time  <= '0;
            r_prev_level <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_fill       <= n_fill;
            r_start_time <= n_start_time;
            r_prev_time  <= n_prev_time;
            r_prev_level <= n_prev_level;
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out      <= n_out;
            r_out_fill <= n_fill;
        end
    end

    // ---------------------------------------------------------------
    // Record store: pause and signal halves. Appends write both, a return
    // to idle writes the signal half only. Both are read at the newest
    // record before this transfer; only this transfer can write that entry
    // in the same cycle, and then its value is known already.
    // ---------------------------------------------------------------
    logic [TIME_W-1:0] pause_rd, signal_rd;
    logic              pause_we, signal_we;
    logic [TIME_W-1:0] signal_wd;
    logic [AW-1:0]     wr_addr, rd_addr;

    assign pause_we  = in_xfer && do_append;
    assign signal_we = in_xfer && (do_append || do_close);
    assign signal_wd = do_close ? passed : '0;
    assign wr_addr   = widx_x[AW-1:0];
    assign rd_addr   = fill_m1[AW-1:0];

    pdr_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_RECORDS)
    ) u_pause_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pause_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (n_out.written_pause),
        .i_rd_en   (in_xfer),
        .i_rd_addr (rd_addr),
        .o_rd_data (pause_rd)
    );

    pdr_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_RECORDS)
    ) u_signal_ram (
        .i_clk     (i_clk),
        .i_wr_en   (signal_we),
        .i_wr_addr (wr_addr),
        .i_wr_data (signal_wd),
        .i_rd_en   (in_xfer),
        .i_rd_addr (rd_addr),
        .o_rd_data (signal_rd)
    );

    // ---------------------------------------------------------------
    // Output assembly
    // ---------------------------------------------------------------
    logic              newest_nz;
    logic [XW-1:0]     complete_x;
    logic [TIME_W-1:0] out_pause;

    assign newest_nz  = r_out.sig_known ? r_out.sig_nz : (signal_rd != '0);
    assign complete_x = (r_out_fill == '0) ? '0
                        : (XW'(r_out_fill) - XW'(!newest_nz));
    assign out_pause  = r_out.pause_from_ram ? pause_rd : r_out.written_pause;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'({r_out.written_signal,
                                       out_pause,
                                       r_out.written_index,
                                       r_out.wrote,
                                       r_out.span,
                                       r_out.last_time,
                                       r_out.first_time,
                                       r_out.store_full,
                                       complete_x[CNT_OUT_W-1:0]});

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_fill_in_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= eff_cap)
        else $error("fill count beyond effective capacity");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (in_kind == KIND_CLEAR)) |=>
            (m_axis_tvalid && (m_axis_tdata[8:0] == '0) && (m_axis_tdata[41:10] == '0)
             && !m_axis_tdata[106]))
        else $error("clear did not empty the recorder");

    a_repeat_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && is_event && (in_level == r_prev_level) && (r_fill != '0)) |=>
            !r_out.wrote)
        else $error("repeated level wrote a record");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_out.wrote) |->
            ((out_pause == '0) && (r_out.written_signal == '0)
             && (r_out.written_index == '0)))
        else $error("record fields set without a write");

endmodule
`default_nettype wire
